// ===== rtl/efg_pkg.sv =====
`timescale 1ns / 1ps

package efg_pkg;

   // default sizes
   localparam int MAX_TERMS_DEF  = 16;
   localparam int PHASE_BITS_DEF = 24;

   // rotator and radius arithmetic
   localparam int CORDIC_STEPS = 18;
   localparam int RADIUS_GAIN  = 50671;
   localparam int RECIP_SHIFT  = 24;
   localparam int VEC_W        = 29;
   localparam int ANGLE_W      = 32;

   // field widths
   localparam int ORIGIN_W    = 12;
   localparam int RADIUS_W    = 10;
   localparam int STEP_W      = 24;
   localparam int COUNT_W     = 5;
   localparam int TIP_W       = 22;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // result range
   localparam logic signed [TIP_W-1:0] TIP_MAX = 22'sh1FFFFF;
   localparam logic signed [TIP_W-1:0] TIP_MIN = 22'sh200000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HARMONIC_COUNT = 3'd4;

   // register reset values
   localparam logic [ORIGIN_W-1:0] ORIGIN_X_RST   = 12'd300;
   localparam logic [ORIGIN_W-1:0] ORIGIN_Y_RST   = 12'd400;
   localparam logic [RADIUS_W-1:0] AMPLITUDE_RST  = 10'd100;
   localparam logic [STEP_W-1:0]   PHASE_STEP_RST = 24'd66754;
   localparam logic [COUNT_W-1:0]  COUNT_RST      = 5'd10;

   // arctangent per step, full turn = 2^32
   localparam logic [ANGLE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'd536870912, 32'd316933389, 32'd167458898, 32'd85004754, 32'd42667331,
      32'd21354463, 32'd10679839, 32'd5340244, 32'd2670164, 32'd1335086,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
      32'd20861, 32'd10430, 32'd5215
   };

   // control that travels alongside each term
   typedef struct packed {
      logic valid;
      logic last;
   } efg_ctl_type;

endpackage

// ===== rtl/efg_radius.sv =====
`timescale 1ns / 1ps

module efg_radius #(
   parameter int  MAX_TERMS = efg_pkg::MAX_TERMS_DEF,
   parameter int  VW        = efg_pkg::VEC_W,
   localparam int IDXW      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  efg_pkg::efg_ctl_type              src_ctl,
   input  logic [IDXW-1:0]                   src_idx,
   input  logic [efg_pkg::ANGLE_W-1:0]       src_turn,
   input  logic [efg_pkg::RADIUS_W-1:0]      amplitude,
   output efg_pkg::efg_ctl_type              dst_ctl,
   output logic signed [VW-1:0]              dst_x,
   output logic signed [efg_pkg::ANGLE_W-1:0] dst_z
);
   import efg_pkg::*;

   localparam int WHOLE_W = 26;
   localparam int FRAC_W  = 17;
   localparam int RCP_W   = RECIP_SHIFT + 1;
   localparam int PROD_W  = FRAC_W + RCP_W;
   localparam int QUO_W   = 18;
   localparam int LEN_W   = 27;

   // per-term constants: gain = q*n + r, reciprocal of n
   logic [15:0]      quo_tab [MAX_TERMS];
   logic [6:0]       rem_tab [MAX_TERMS];
   logic [RCP_W-1:0] rcp_tab [MAX_TERMS];

   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_tab
      localparam int N = 2 * k + 1;
      localparam int Q = RADIUS_GAIN / N;
      localparam int R = RADIUS_GAIN % N;
      localparam int M = (2 ** RECIP_SHIFT + N - 1) / N;
      assign quo_tab[k] = 16'(Q);
      assign rem_tab[k] = 7'(R);
      assign rcp_tab[k] = RCP_W'(M);
   end

   efg_ctl_type                s1_ctl_ff, s1_ctl_in, s2_ctl_ff, s2_ctl_in, s3_ctl_ff, s3_ctl_in;
   logic [WHOLE_W-1:0]         s1_whole_ff, s1_whole_in, s2_whole_ff, s2_whole_in;
   logic [FRAC_W-1:0]          s1_frac_ff, s1_frac_in;
   logic [ANGLE_W-1:0]         s1_turn_ff, s1_turn_in, s2_turn_ff, s2_turn_in;
   logic [QUO_W-1:0]           s2_quo_ff, s2_quo_in;
   logic [PROD_W-1:0]          prod;
   logic [LEN_W-1:0]           len;
   logic signed [VW-1:0]       vlen;
   logic                       fold;
   logic signed [VW-1:0]       s3_x_ff, s3_x_in;
   logic signed [ANGLE_W-1:0]  s3_z_ff, s3_z_in;

   // reciprocal follows the term into stage 2
   logic [RCP_W-1:0] rcp_tab_sel_ff;

   // stage 1: whole part b*q and remainder b*r + n/2
   assign s1_ctl_in   = src_ctl;
   assign s1_whole_in = WHOLE_W'(amplitude) * WHOLE_W'(quo_tab[src_idx]);
   assign s1_frac_in  = FRAC_W'(amplitude) * FRAC_W'(rem_tab[src_idx]) + FRAC_W'(src_idx);
   assign s1_turn_in  = src_turn;

   // stage 2: divide the remainder part by reciprocal multiply
   assign prod        = PROD_W'(s1_frac_ff) * PROD_W'(rcp_tab_sel_ff);
   assign s2_ctl_in   = s1_ctl_ff;
   assign s2_quo_in   = QUO_W'(prod >> RECIP_SHIFT);
   assign s2_whole_in = s1_whole_ff;
   assign s2_turn_in  = s1_turn_ff;

   // stage 3: start length and half-turn fold
   assign len       = LEN_W'(s2_whole_ff) + LEN_W'(s2_quo_ff);
   assign vlen      = signed'(VW'(len));
   assign fold      = s2_turn_ff[ANGLE_W-1] ^ s2_turn_ff[ANGLE_W-2];
   assign s3_ctl_in = s2_ctl_ff;
   assign s3_x_in   = fold ? -vlen : vlen;
   assign s3_z_in   = signed'(s2_turn_ff ^ {fold, {(ANGLE_W-1){1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else begin
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
         s3_ctl_ff <= s3_ctl_in;
      end
      s1_whole_ff    <= s1_whole_in;
      s1_frac_ff     <= s1_frac_in;
      s1_turn_ff     <= s1_turn_in;
      rcp_tab_sel_ff <= rcp_tab[src_idx];
      s2_whole_ff    <= s2_whole_in;
      s2_quo_ff      <= s2_quo_in;
      s2_turn_ff     <= s2_turn_in;
      s3_x_ff        <= s3_x_in;
      s3_z_ff        <= s3_z_in;
   end

   assign dst_ctl = s3_ctl_ff;
   assign dst_x   = s3_x_ff;
   assign dst_z   = s3_z_ff;

endmodule

// ===== rtl/efg_cordic_cell.sv =====
`timescale 1ns / 1ps

module efg_cordic_cell #(
   parameter int STAGE = 0,
   parameter int VW    = efg_pkg::VEC_W
) (
   input  logic                               clock,
   input  logic                               reset,
   input  efg_pkg::efg_ctl_type               src_ctl,
   input  logic signed [VW-1:0]               src_x,
   input  logic signed [VW-1:0]               src_y,
   input  logic signed [efg_pkg::ANGLE_W-1:0] src_z,
   output efg_pkg::efg_ctl_type               dst_ctl,
   output logic signed [VW-1:0]               dst_x,
   output logic signed [VW-1:0]               dst_y,
   output logic signed [efg_pkg::ANGLE_W-1:0] dst_z
);
   import efg_pkg::*;

   logic signed [VW-1:0]      dx, dy;
   logic signed [ANGLE_W-1:0] atan;
   efg_ctl_type               ctl_ff, ctl_in;
   logic signed [VW-1:0]      x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0] z_ff, z_in;

   // one micro-rotation, floor shifts
   assign dx   = src_y >>> STAGE;
   assign dy   = src_x >>> STAGE;
   assign atan = signed'(ATAN_TURN[STAGE]);

   always_comb begin
      ctl_in = src_ctl;
      if (!src_z[ANGLE_W-1]) begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - atan;
      end else begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + atan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign dst_ctl = ctl_ff;
   assign dst_x   = x_ff;
   assign dst_y   = y_ff;
   assign dst_z   = z_ff;

endmodule

// ===== rtl/fourier_epicycle_tip_generator.sv =====
`timescale 1ns / 1ps
// one item at a time: the phase ring turns once per item
// and terms stream one per cycle through a 3-stage radius unit and an 18-cell rotator chain
// a new item is taken the cycle after its result is posted,
// later while an earlier result still waits in the output register
// reset (synchronous) restores register defaults and zeroes every term phase

module fourier_epicycle_tip_generator #(
   parameter int MAX_TERMS  = efg_pkg::MAX_TERMS_DEF,
   parameter int PHASE_BITS = efg_pkg::PHASE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_advance,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [efg_pkg::TIP_W-1:0]      rsp_tip_x,
   output logic signed [efg_pkg::TIP_W-1:0]      rsp_tip_y,
   input  logic                                  csr_we,
   input  logic [efg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [efg_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import efg_pkg::*;

   localparam int IDXW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int CW   = $clog2(MAX_TERMS + 1);
   localparam int SUMW = VEC_W + IDXW + 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FINISH} state_type;

   // configuration registers
   logic [ORIGIN_W-1:0] origin_x_ff, origin_y_ff;
   logic [RADIUS_W-1:0] amplitude_ff;
   logic [STEP_W-1:0]   phase_step_ff;
   logic [COUNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= ORIGIN_X_RST;
         origin_y_ff   <= ORIGIN_Y_RST;
         amplitude_ff  <= AMPLITUDE_RST;
         phase_step_ff <= PHASE_STEP_RST;
         count_ff      <= COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_ORIGIN_X:       origin_x_ff   <= csr_wdata[ORIGIN_W-1:0];
            REG_ORIGIN_Y:       origin_y_ff   <= csr_wdata[ORIGIN_W-1:0];
            REG_AMPLITUDE:      amplitude_ff  <= csr_wdata[RADIUS_W-1:0];
            REG_PHASE_STEP:     phase_step_ff <= csr_wdata[STEP_W-1:0];
            REG_HARMONIC_COUNT: count_ff      <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // terms in use, clipped to one .. MAX_TERMS
   logic [CW-1:0] ec;
   always_comb begin
      if (count_ff == '0) begin
         ec = CW'(1);
      end else if (int'(count_ff) > MAX_TERMS) begin
         ec = CW'(MAX_TERMS);
      end else begin
         ec = CW'(count_ff);
      end
   end

   // sequencer state and result registers
   state_type              state_ff, state_in;
   logic [IDXW-1:0]        cnt_ff, cnt_in;
   logic [PHASE_BITS-1:0]  inc_ff, inc_in;
   logic                   adv_ff, adv_in;
   logic                   done_ff, done_in;
   logic signed [SUMW-1:0] sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [TIP_W-1:0] tip_x_ff, tip_x_in, tip_y_ff, tip_y_in;

   logic [PHASE_BITS-1:0]  step_w;
   logic [PHASE_BITS-1:0]  phase_ff [MAX_TERMS];
   logic [PHASE_BITS-1:0]  tail_in;
   logic                   ring_shift;

   efg_ctl_type             iss_ctl;
   logic [ANGLE_W-1:0]      iss_turn;
   efg_ctl_type             cor_ctl [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0] cor_x [CORDIC_STEPS+1];
   logic signed [VEC_W-1:0] cor_y [CORDIC_STEPS+1];
   logic signed [ANGLE_W-1:0] cor_z [CORDIC_STEPS+1];

   logic signed [SUMW:0]   rnd_x, rnd_y, shx, shy;
   logic signed [SUMW+1:0] tfx, tfy;

   assign step_w     = PHASE_BITS'(32'(phase_step_ff));
   assign req_ready  = (state_ff == ST_IDLE);
   assign ring_shift = (state_ff == ST_RUN);

   // term ring: head goes to the radius unit and re-enters at the tail, advanced if the item asks
   assign tail_in = adv_ff ? phase_ff[0] + inc_ff : phase_ff[0];

   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_ring
      always_ff @(posedge clock) begin
         if (reset) begin
            phase_ff[k] <= '0;
         end else if (ring_shift) begin
            if (k == MAX_TERMS - 1) begin
               phase_ff[k] <= tail_in;
            end else begin
               phase_ff[k] <= phase_ff[(k + 1) % MAX_TERMS];
            end
         end
      end
   end

   // issue the head term
   assign iss_ctl.valid = ring_shift && (CW'(cnt_ff) < ec);
   assign iss_ctl.last  = (CW'(cnt_ff) == ec - CW'(1));
   assign iss_turn      = 32'(phase_ff[0]) << (32 - PHASE_BITS);

   efg_radius #(
      .MAX_TERMS (MAX_TERMS),
      .VW        (VEC_W)
   ) u_radius (
      .clock     (clock),
      .reset     (reset),
      .src_ctl   (iss_ctl),
      .src_idx   (cnt_ff),
      .src_turn  (iss_turn),
      .amplitude (amplitude_ff),
      .dst_ctl   (cor_ctl[0]),
      .dst_x     (cor_x[0]),
      .dst_z     (cor_z[0])
   );

   assign cor_y[0] = '0;

   // rotator chain, one micro-rotation per cell
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      efg_cordic_cell #(
         .STAGE (i),
         .VW    (VEC_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .src_ctl (cor_ctl[i]),
         .src_x   (cor_x[i]),
         .src_y   (cor_y[i]),
         .src_z   (cor_z[i]),
         .dst_ctl (cor_ctl[i+1]),
         .dst_x   (cor_x[i+1]),
         .dst_y   (cor_y[i+1]),
         .dst_z   (cor_z[i+1])
      );
   end

   // round to 1/256 pixel, add origin
   assign rnd_x = {sum_x_ff[SUMW-1], sum_x_ff} + (SUMW+1)'(128);
   assign rnd_y = {sum_y_ff[SUMW-1], sum_y_ff} + (SUMW+1)'(128);
   assign shx   = rnd_x >>> 8;
   assign shy   = rnd_y >>> 8;
   assign tfx   = {shx[SUMW], shx} + (SUMW+2)'({origin_x_ff, 8'd0});
   assign tfy   = {shy[SUMW], shy} + (SUMW+2)'({origin_y_ff, 8'd0});

   function automatic logic signed [TIP_W-1:0] clamp_tip(input logic signed [SUMW+1:0] v);
      logic signed [TIP_W-1:0] r;
      if (v > TIP_MAX) begin
         r = TIP_MAX;
      end else if (v < TIP_MIN) begin
         r = TIP_MIN;
      end else begin
         r = v[TIP_W-1:0];
      end
      return r;
   endfunction

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      inc_in       = inc_ff;
      adv_in       = adv_ff;
      done_in      = done_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      rsp_valid_in = rsp_valid_ff;
      tip_x_in     = tip_x_ff;
      tip_y_in     = tip_y_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // accumulate rotated terms
      if (cor_ctl[CORDIC_STEPS].valid) begin
         sum_x_in = sum_x_ff + {{(SUMW-VEC_W){cor_x[CORDIC_STEPS][VEC_W-1]}},
                                cor_x[CORDIC_STEPS]};
         sum_y_in = sum_y_ff + {{(SUMW-VEC_W){cor_y[CORDIC_STEPS][VEC_W-1]}},
                                cor_y[CORDIC_STEPS]};
         if (cor_ctl[CORDIC_STEPS].last) begin
            done_in = 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               inc_in   = step_w;
               adv_in   = req_advance;
               done_in  = 1'b0;
               sum_x_in = '0;
               sum_y_in = '0;
            end
         end
         ST_RUN: begin
            inc_in = inc_ff + (step_w << 1);
            cnt_in = IDXW'(cnt_ff + 1'b1);
            if (cnt_ff == IDXW'(MAX_TERMS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               tip_x_in     = clamp_tip(tfx);
               tip_y_in     = clamp_tip(tfy);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
      cnt_ff   <= cnt_in;
      inc_ff   <= inc_in;
      adv_ff   <= adv_in;
      sum_x_ff <= sum_x_in;
      sum_y_ff <= sum_y_in;
      tip_x_ff <= tip_x_in;
      tip_y_ff <= tip_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tip_x = tip_x_ff;
   assign rsp_tip_y = tip_y_ff;

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while previous item still running");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!cor_ctl[CORDIC_STEPS].valid && !iss_ctl.valid))
      else $error("term in flight while sequencer idle");

   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) |=> (rsp_valid && req_ready))
      else $error("finished item not posted to output register");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import efg_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 64;
   localparam int RANDOM_ITEMS = 1350;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_FIRST = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [TIP_W-1:0] x;
      logic [TIP_W-1:0] y;
   } tip_point_type;

   // predicts the chained tip of every item and checks results in order
   class tip_book_type;
      bit [ORIGIN_W-1:0] org_x;
      bit [ORIGIN_W-1:0] org_y;
      bit [RADIUS_W-1:0] radius;
      bit [STEP_W-1:0]   step;
      bit [COUNT_W-1:0]  terms;
      bit [PHASE_BITS_DEF-1:0] phase [MAX_TERMS_DEF];
      tip_point_type tips_due [$];
      int errors;

      function new();
         org_x = ORIGIN_X_RST;
         org_y = ORIGIN_Y_RST;
         radius = AMPLITUDE_RST;
         step = PHASE_STEP_RST;
         terms = COUNT_RST;
         foreach (phase[k]) phase[k] = '0;
         errors = 0;
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t mismatch: %s", $realtime, what);
      endtask

      // register fields keep only their own width, unknown indexes drop out
      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            REG_ORIGIN_X:       org_x = d[ORIGIN_W-1:0];
            REG_ORIGIN_Y:       org_y = d[ORIGIN_W-1:0];
            REG_AMPLITUDE:      radius = d[RADIUS_W-1:0];
            REG_PHASE_STEP:     step = d[STEP_W-1:0];
            REG_HARMONIC_COUNT: terms = d[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // cordic rotation of (len, 0) by a 32-bit turn word
      function void rotate(longint signed len, bit [ANGLE_W-1:0] a,
                           output longint signed ox, output longint signed oy);
         longint signed x, y, z, dx, dy;
         int i;
         x = len;
         y = 0;
         if (a[31:30] == 2'b01 || a[31:30] == 2'b10) begin
            x = -x;
            a = a - 32'h8000_0000;
         end
         z = longint'($signed(a));
         for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= longint'(ATAN_TURN[i]);
            end else begin
               x += dx;
               y -= dy;
               z += longint'(ATAN_TURN[i]);
            end
         end
         ox = x;
         oy = y;
      endfunction

      function longint signed clamp_tip(longint signed v);
         if (v > longint'(TIP_MAX)) return longint'(TIP_MAX);
         if (v < longint'(TIP_MIN)) return longint'(TIP_MIN);
         return v;
      endfunction

      // sum the active phasors, then advance every phase if asked
      function void note_item(bit adv);
         longint signed sx, sy, vx, vy, len, tx, ty;
         int used, k, n;
         tip_point_type p;
         used = (terms == 0) ? 1 : ((terms > MAX_TERMS_DEF) ? MAX_TERMS_DEF : terms);
         sx = 0;
         sy = 0;
         for (k = 0; k < used; k++) begin
            n = 2 * k + 1;
            len = (longint'(radius) * RADIUS_GAIN + n / 2) / n;
            rotate(len, {phase[k], 8'h00}, vx, vy);
            sx += vx;
            sy += vy;
         end
         tx = clamp_tip(longint'(org_x) * 256 + ((sx + 128) >>> 8));
         ty = clamp_tip(longint'(org_y) * 256 + ((sy + 128) >>> 8));
         p.x = tx[TIP_W-1:0];
         p.y = ty[TIP_W-1:0];
         tips_due.insert(tips_due.size(), p);
         if (adv) begin
            for (k = 0; k < MAX_TERMS_DEF; k++)
               phase[k] = phase[k] + PHASE_BITS_DEF'(step * (2 * k + 1));
         end
      endfunction

      task check_tip(logic [TIP_W-1:0] got_x, logic [TIP_W-1:0] got_y);
         tip_point_type want;
         if (tips_due.size() == 0) begin
            report_mismatch($sformatf("tip (%0d, %0d) with no item waiting",
                                      $signed(got_x), $signed(got_y)));
         end else begin
            want = tips_due.pop_front();
            if (got_x !== want.x)
               report_mismatch($sformatf("tip_x got %0d want %0d",
                                         $signed(got_x), $signed(want.x)));
            if (got_y !== want.y)
               report_mismatch($sformatf("tip_y got %0d want %0d",
                                         $signed(got_y), $signed(want.y)));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_advance;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [TIP_W-1:0] rsp_tip_x;
   logic signed [TIP_W-1:0] rsp_tip_y;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tip_book_type book;
   bit calm;
   int cycles = 0;
   int stall_left;
   int ready_draw;

   fourier_epicycle_tip_generator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_advance(req_advance),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tip_x(rsp_tip_x),
      .rsp_tip_y(rsp_tip_y),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // mostly short gaps, a few long ones, none in calm stretches
   function int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("fourier_epicycle_tip_generator regression: fail");
         $finish;
      end
   end

   // result side stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         ready_draw = pick_gap();
         rsp_ready <= (ready_draw == 0);
         stall_left <= (ready_draw == 0) ? 0 : ready_draw - 1;
      end
   end

   // watch both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) book.check_tip(rsp_tip_x, rsp_tip_y);
         if (req_valid && req_ready) book.note_item(req_advance);
      end
   end

   task send_item(bit adv);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_advance <= adv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      book.set_reg(idx, d);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // hold the sender until every result is back and the block is quiet
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.tips_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function logic [CSR_DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return CSR_DATA_W'($urandom());
   endfunction

   task shuffle_config();
      int idx;
      for (idx = REG_ORIGIN_X; idx <= REG_HARMONIC_COUNT; idx++)
         if ($urandom_range(0, 9) < 6) write_reg(idx[CSR_INDEX_W-1:0], pick_value());
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_INDEX_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)),
                   CSR_DATA_W'($urandom()));
   endtask

   initial begin
      int idx;
      int left;
      int burst;
      reset = 1'b1;
      req_valid = 1'b0;
      req_advance = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      book = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, phases at zero
      send_item(1'b0);
      send_item(1'b0);
      drain();

      // largest radius, all terms aligned: furthest tip in x
      write_reg(REG_ORIGIN_X, 24'd4095);
      write_reg(REG_ORIGIN_Y, 24'd0);
      write_reg(REG_AMPLITUDE, 24'd1023);
      write_reg(REG_HARMONIC_COUNT, 24'd16);
      write_reg(REG_PHASE_STEP, 24'h800000);
      send_item(1'b0);
      send_item(1'b1);
      drain();

      // every term at a half turn with origin at zero: lowest tip in x; the last item sees the phases back at zero
      write_reg(REG_ORIGIN_X, 24'd0);
      write_reg(REG_ORIGIN_Y, 24'd4095);
      send_item(1'b0);
      send_item(1'b1);
      send_item(1'b0);
      drain();

      // zero term count runs one term
      write_reg(REG_HARMONIC_COUNT, 24'd0);
      write_reg(REG_PHASE_STEP, 24'h0AAAAB);
      send_item(1'b1);
      send_item(1'b1);
      send_item(1'b0);
      drain();

      // count above the bank size, largest step
      write_reg(REG_HARMONIC_COUNT, 24'd31);
      write_reg(REG_PHASE_STEP, 24'hFFFFFF);
      send_item(1'b1);
      send_item(1'b1);
      send_item(1'b1);
      drain();

      // count just past the bank, zero radius leaves only the origin
      write_reg(REG_HARMONIC_COUNT, 24'd17);
      write_reg(REG_AMPLITUDE, 24'd0);
      send_item(1'b1);
      send_item(1'b0);
      drain();

      // unused indexes and bits above each register's width
      for (idx = REG_UNUSED_FIRST; idx <= REG_UNUSED_LAST; idx++)
         write_reg(idx[CSR_INDEX_W-1:0], 24'hFFFFFF);
      write_reg(REG_ORIGIN_X, 24'hABC123);
      write_reg(REG_ORIGIN_Y, 24'h5A5FED);
      write_reg(REG_AMPLITUDE, 24'hFFFC01);
      write_reg(REG_HARMONIC_COUNT, 24'hFFFFE1);
      write_reg(REG_PHASE_STEP, CSR_DATA_W'($urandom()));
      send_item(1'b1);
      send_item(1'b1);
      send_item(1'b1);
      send_item(1'b0);
      drain();

      // back to defaults with one term and the smallest step
      write_reg(REG_ORIGIN_X, CSR_DATA_W'(ORIGIN_X_RST));
      write_reg(REG_ORIGIN_Y, CSR_DATA_W'(ORIGIN_Y_RST));
      write_reg(REG_AMPLITUDE, CSR_DATA_W'(AMPLITUDE_RST));
      write_reg(REG_HARMONIC_COUNT, 24'd1);
      write_reg(REG_PHASE_STEP, 24'd1);
      send_item(1'b1);
      send_item(1'b1);
      drain();

      // random phases with fresh settings between them
      left = RANDOM_ITEMS;
      while (left > 0) begin
         shuffle_config();
         calm = ($urandom_range(0, 4) == 0);
         burst = $urandom_range(20, 80);
         if (burst > left) burst = left;
         repeat (burst) send_item($urandom_range(0, 4) != 0);
         left -= burst;
         drain();
         calm = 1'b0;
      end

      if (book.errors == 0)
         $display("fourier_epicycle_tip_generator regression: pass");
      else
         $display("fourier_epicycle_tip_generator regression: fail");
      $finish;
   end

endmodule
